>>> hw/rtl/eul_pkg.sv
// shared types, constants, sine table and rounding helper for the euler xyz rotation block
package eul_pkg;

  localparam int COMP_W           = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int ANGLE_W          = 16;
  localparam int TAB_W            = 15;
  localparam int TRIG_W           = TAB_W + 1;
  localparam int FRAC_W           = 15;
  localparam int FULL_TURN        = 4 * SINE_TABLE_DEPTH;
  localparam int IDX_W            = $clog2(FULL_TURN);
  localparam int PIDX_W           = ANGLE_W + IDX_W + 1;
  localparam int ADDR_W           = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MUL_W            = COMP_W + TRIG_W;
  localparam int SUM_W            = MUL_W + 1;

  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint TAB_MAX      = (64'sd1 <<< TAB_W) - 64'sd1;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'({1'b0, {(COMP_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN    = -SAT_MAX - SUM_W'(1);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic [ANGLE_W-1:0]       ang_x;
    logic [ANGLE_W-1:0]       ang_y;
    logic [ANGLE_W-1:0]       ang_z;
  } item_t;

  typedef logic [TAB_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // long division for the table build, operands are never negative
  function automatic longint div_pos(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 <<< b);
      end
    end
    return quo;
  endfunction

  // quarter wave in unsigned q0.15 from a q30 taylor series, worked out at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    longint    v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (longint'(k) * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n < 17; n += 2) begin
        term = (term * x2) >>> 30;
        term = div_pos(term, longint'((n + 1) * (n + 2)));
        if ((((n + 1) >> 1) & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        v = 0;
      end else begin
        v = (sum + 64'sd16384) >>> 15;
      end
      if (v > TAB_MAX) begin
        v = TAB_MAX;
      end
      tab[k] = TAB_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // floor by 2^15 of a biased sum, then clamp to the component range
  function automatic logic signed [COMP_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    logic signed [COMP_W-1:0] res;
    sh = s >>> FRAC_W;
    if (sh > SAT_MAX) begin
      res = SAT_MAX[COMP_W-1:0];
    end else if (sh < SAT_MIN) begin
      res = SAT_MIN[COMP_W-1:0];
    end else begin
      res = sh[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/eul_rot.sv
// one plane rotation about a coordinate axis: table read, multiply, round and saturate
module eul_rot (
  input  logic           clk,
  input  logic           rst,
  input  eul_pkg::axis_t axis,
  input  logic           up_valid,
  output logic           up_ready,
  input  eul_pkg::item_t up_item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output eul_pkg::item_t dn_item
);

  // stage enables, each stage moves when empty or when the next one moves
  logic en1, en2, en3;
  logic v1, v2, v3;

  assign en3      = !v3 || dn_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  // stage 0: angle to table addresses
  logic [eul_pkg::ANGLE_W-1:0] ang;
  logic [eul_pkg::PIDX_W-1:0]  idx_prod;
  logic [eul_pkg::IDX_W-1:0]   idx;
  logic [eul_pkg::IDX_W-1:0]   idx_off;
  logic [eul_pkg::IDX_W-1:0]   idx_rem;
  logic [1:0]                  quad;
  logic [eul_pkg::ADDR_W-1:0]  addr_a;
  logic [eul_pkg::ADDR_W-1:0]  addr_b;

  always_comb begin
    unique case (axis)
      eul_pkg::AXIS_X: ang = up_item.ang_x;
      eul_pkg::AXIS_Y: ang = up_item.ang_y;
      eul_pkg::AXIS_Z: ang = up_item.ang_z;
      default:         ang = up_item.ang_x;
    endcase
  end

  assign idx_prod = eul_pkg::PIDX_W'(ang) * eul_pkg::PIDX_W'(eul_pkg::FULL_TURN);
  assign idx      = idx_prod[eul_pkg::ANGLE_W +: eul_pkg::IDX_W];

  always_comb begin
    priority if (idx >= eul_pkg::IDX_W'(3 * eul_pkg::SINE_TABLE_DEPTH)) begin
      quad    = 2'd3;
      idx_off = eul_pkg::IDX_W'(3 * eul_pkg::SINE_TABLE_DEPTH);
    end else if (idx >= eul_pkg::IDX_W'(2 * eul_pkg::SINE_TABLE_DEPTH)) begin
      quad    = 2'd2;
      idx_off = eul_pkg::IDX_W'(2 * eul_pkg::SINE_TABLE_DEPTH);
    end else if (idx >= eul_pkg::IDX_W'(eul_pkg::SINE_TABLE_DEPTH)) begin
      quad    = 2'd1;
      idx_off = eul_pkg::IDX_W'(eul_pkg::SINE_TABLE_DEPTH);
    end else begin
      quad    = 2'd0;
      idx_off = '0;
    end
  end

  assign idx_rem = idx - idx_off;
  assign addr_a  = eul_pkg::ADDR_W'(idx_rem);
  assign addr_b  = eul_pkg::ADDR_W'(eul_pkg::SINE_TABLE_DEPTH) - addr_a;

  // stage 1 registers: table words at r and depth - r
  eul_pkg::item_t             item1;
  logic [1:0]                 quad1;
  logic                       zero1;
  logic [eul_pkg::TAB_W-1:0]  tab_a;
  logic [eul_pkg::TAB_W-1:0]  tab_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= up_valid;
    end
    if (en1) begin
      item1 <= up_item;
      quad1 <= quad;
      zero1 <= (ang == '0);
      tab_a <= eul_pkg::SINE_TAB[addr_a];
      tab_b <= eul_pkg::SINE_TAB[addr_b];
    end
  end

  // stage 1 logic: signed sine and cosine, operand pick
  logic signed [eul_pkg::TRIG_W-1:0] ta, tb, sin_v, cos_v;
  logic signed [eul_pkg::COMP_W-1:0] p1, q1;

  assign ta = signed'(eul_pkg::TRIG_W'(tab_a));
  assign tb = signed'(eul_pkg::TRIG_W'(tab_b));

  always_comb begin
    unique case (quad1)
      2'd0: begin sin_v = ta;  cos_v = tb;  end
      2'd1: begin sin_v = tb;  cos_v = -ta; end
      2'd2: begin sin_v = -ta; cos_v = -tb; end
      2'd3: begin sin_v = -tb; cos_v = ta;  end
      default: begin sin_v = ta; cos_v = tb; end
    endcase
  end

  always_comb begin
    unique case (axis)
      eul_pkg::AXIS_X: begin p1 = item1.y; q1 = item1.z; end
      eul_pkg::AXIS_Y: begin p1 = item1.z; q1 = item1.x; end
      eul_pkg::AXIS_Z: begin p1 = item1.x; q1 = item1.y; end
      default:         begin p1 = item1.y; q1 = item1.z; end
    endcase
  end

  // stage 2 registers: the four products
  eul_pkg::item_t                   item2;
  logic                             zero2;
  logic signed [eul_pkg::MUL_W-1:0] pc, qs, qc, ps;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      item2 <= item1;
      zero2 <= zero1;
      pc    <= p1 * cos_v;
      qs    <= q1 * sin_v;
      qc    <= q1 * cos_v;
      ps    <= p1 * sin_v;
    end
  end

  // stage 2 logic: sums with rounding bias, saturate, write back
  logic signed [eul_pkg::SUM_W-1:0]  sum_p, sum_q;
  logic signed [eul_pkg::COMP_W-1:0] np, nq;
  eul_pkg::item_t                    item3_next;

  assign sum_p = eul_pkg::SUM_W'(pc) - eul_pkg::SUM_W'(qs) + eul_pkg::ROUND_BIAS;
  assign sum_q = eul_pkg::SUM_W'(qc) + eul_pkg::SUM_W'(ps) + eul_pkg::ROUND_BIAS;
  assign np    = eul_pkg::round_sat(sum_p);
  assign nq    = eul_pkg::round_sat(sum_q);

  always_comb begin
    item3_next = item2;
    // zero angle leaves the vector untouched
    if (!zero2) begin
      unique case (axis)
        eul_pkg::AXIS_X: begin item3_next.y = np; item3_next.z = nq; end
        eul_pkg::AXIS_Y: begin item3_next.z = np; item3_next.x = nq; end
        eul_pkg::AXIS_Z: begin item3_next.x = np; item3_next.y = nq; end
        default:         begin item3_next.y = np; item3_next.z = nq; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      dn_item <= item3_next;
    end
  end

  assign dn_valid = v3;

endmodule

>>> hw/rtl/euler_xyz_vector_rotation.sv
// Rotates a Q16.16 vector about x, then y, then z by 16-bit binary angles (65536 per turn).
// One beat is accepted every clock cycle unless in_stall is high, with three register stages per
// axis (sine table read, multiply, round and saturate). Each axis has its own 1025-entry
// quarter-wave sine table read at two addresses per cycle, which gives sine and cosine
// together. Empty stages fill while the output is stalled, so in_stall rises only once all
// nine stages hold a beat and the output beat is stalled. A zero angle passes its
// components through exactly; every rotated component is rounded and saturated to 32 bits.
module euler_xyz_vector_rotation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [eul_pkg::COMP_W-1:0] vec_x,
  input  logic signed [eul_pkg::COMP_W-1:0] vec_y,
  input  logic signed [eul_pkg::COMP_W-1:0] vec_z,
  input  logic [eul_pkg::ANGLE_W-1:0]       angle_x,
  input  logic [eul_pkg::ANGLE_W-1:0]       angle_y,
  input  logic [eul_pkg::ANGLE_W-1:0]       angle_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [eul_pkg::COMP_W-1:0] out_x,
  output logic signed [eul_pkg::COMP_W-1:0] out_y,
  output logic signed [eul_pkg::COMP_W-1:0] out_z
);

  eul_pkg::item_t in_item, xy_item, yz_item, res_item;
  logic           in_ready;
  logic           xy_valid, xy_ready, yz_valid, yz_ready;

  assign in_item.x     = vec_x;
  assign in_item.y     = vec_y;
  assign in_item.z     = vec_z;
  assign in_item.ang_x = angle_x;
  assign in_item.ang_y = angle_y;
  assign in_item.ang_z = angle_z;

  eul_rot u_rot_x (
    .clk      (clk),
    .rst      (rst),
    .axis     (eul_pkg::AXIS_X),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (xy_valid),
    .dn_ready (xy_ready),
    .dn_item  (xy_item)
  );

  eul_rot u_rot_y (
    .clk      (clk),
    .rst      (rst),
    .axis     (eul_pkg::AXIS_Y),
    .up_valid (xy_valid),
    .up_ready (xy_ready),
    .up_item  (xy_item),
    .dn_valid (yz_valid),
    .dn_ready (yz_ready),
    .dn_item  (yz_item)
  );

  eul_rot u_rot_z (
    .clk      (clk),
    .rst      (rst),
    .axis     (eul_pkg::AXIS_Z),
    .up_valid (yz_valid),
    .up_ready (yz_ready),
    .up_item  (yz_item),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_item  (res_item)
  );

  assign in_stall = !in_ready;
  assign out_x    = res_item.x;
  assign out_y    = res_item.y;
  assign out_z    = res_item.z;

  // input back-pressure only comes from a stalled, full output
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output beat is not stalled");

  // an empty output stage means the whole chain can move
  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no output beat pending");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output beat present right after reset");

endmodule
